FILE: design/ghp_pkg.sv
// Shared types and constants for the generational handle pool.
package ghp_pkg;
  localparam int Capacity = 1024;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);

  localparam logic [1:0] RegPoolEnable = 2'd0;

  typedef enum logic [2:0] {
    ACT_ALLOC = 3'd0, ACT_FREE = 3'd1, ACT_SET_STATE = 3'd2, ACT_GET_STATE = 3'd3,
    ACT_SET_DATA = 3'd4, ACT_GET_DATA = 3'd5, ACT_VALIDATE = 3'd6, ACT_NONE = 3'd7
  } action_t;

  localparam logic [2:0] StEmpty = 3'd0;
  localparam logic [2:0] StLoading = 3'd1;
  localparam logic [2:0] StPending = 3'd2;

  typedef enum logic [1:0] {S_IDLE, S_CLEAR, S_READ, S_EXEC} fsm_state_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  res_type;
    logic [7:0]  pool_id;
    logic [15:0] handle_index;
    logic [31:0] handle_generation;
    logic [2:0]  new_state;
    logic [63:0] data_word;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] out_index;
    logic [31:0] out_generation;
    logic [7:0]  out_pool_id;
    logic [2:0]  out_state;
    logic [63:0] out_data;
    logic [16:0] active_count;
  } rsp_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic read;
    logic exec;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
  } sts_t;
endpackage

FILE: design/ghp_ctrl.sv
// Sequencer: clearing pass, then capture, read and execute per item.
module ghp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  ghp_pkg::sts_t sts,
  output logic          busy,
  output ghp_pkg::cmd_t cmd
);
  import ghp_pkg::*;
  fsm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (sts.clear_done) state_next = S_IDLE;
      S_IDLE:  if (start) state_next = S_READ;
      S_READ:  state_next = S_EXEC;
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != S_IDLE);
    cmd = '0;
    case (state)
      S_CLEAR: cmd.clear = 1'b1;
      S_IDLE:  cmd.capture = start;
      S_READ:  cmd.read = 1'b1;
      S_EXEC:  cmd.exec = 1'b1;
      default: cmd = '0;
    endcase
  end
endmodule

FILE: design/ghp_dp.sv
// Slot memories, free list, counters and result register.
module ghp_dp (
  input  logic          clk,
  input  logic          rst,
  input  ghp_pkg::cmd_t cmd,
  input  ghp_pkg::req_t req,
  input  logic          pool_enable,
  output ghp_pkg::sts_t sts,
  output logic          done,
  output ghp_pkg::rsp_t rsp
);
  import ghp_pkg::*;

  logic [2:0]  mem_state [Capacity];
  logic [31:0] mem_gen   [Capacity];
  logic [63:0] mem_data  [Capacity];
  logic [7:0]  mem_type  [Capacity];
  logic [IdxW-1:0] mem_stack [Capacity];

  req_t r;
  logic [IdxW-1:0] clr_ptr;
  logic [CntW-1:0] stack_depth, fresh_next, active_total;
  logic [2:0]  rd_state;
  logic [31:0] rd_gen;
  logic [63:0] rd_data;
  logic [IdxW-1:0] rd_top;
  logic [IdxW-1:0] slot;
  logic alloc, in_range, pop, fresh;

  // Pick the slot the item works on: popped, fresh or the handle's.
  always_comb begin
    pop = (stack_depth != '0);
    fresh = (fresh_next != '0);
    in_range = ({1'b0, r.handle_index} < 17'(Capacity));
    alloc = (r.action == ACT_ALLOC);
    if (!alloc) slot = r.handle_index[IdxW-1:0];
    else if (pop) slot = rd_top;
    else slot = IdxW'(fresh_next - 1'b1);
  end

  assign sts.clear_done = (clr_ptr == IdxW'(Capacity - 1));

  always_ff @(posedge clk) begin
    if (rst) clr_ptr <= '0;
    else if (cmd.clear) clr_ptr <= clr_ptr + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) r <= req;
  end

  // At capture the stack top is registered, since allocate needs it to pick the slot.
  logic [IdxW-1:0] top_q;
  always_ff @(posedge clk) begin
    if (cmd.capture) top_q <= mem_stack[IdxW'(stack_depth - 1'b1)];
  end
  assign rd_top = top_q;

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_state <= mem_state[slot];
      rd_gen <= mem_gen[slot];
      rd_data <= mem_data[slot];
    end
  end

  logic valid, have, was_act, now_act;
  logic [2:0] wr_state;
  logic st_we;
  always_comb begin
    valid = pool_enable && in_range && (rd_gen == r.handle_generation) &&
            (rd_state != StEmpty) && (rd_state != StPending);
    have = pool_enable && (pop || fresh);
    was_act = (rd_state != StEmpty) && (rd_state != StPending);
    st_we = 1'b0;
    wr_state = rd_state;
    if (alloc && have) begin
      st_we = 1'b1; wr_state = StLoading;
    end else if (valid && r.action == ACT_FREE) begin
      st_we = 1'b1; wr_state = StEmpty;
    end else if (valid && r.action == ACT_SET_STATE) begin
      st_we = 1'b1; wr_state = r.new_state;
    end
    now_act = (wr_state != StEmpty) && (wr_state != StPending);
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem_state[clr_ptr] <= StEmpty;
      mem_gen[clr_ptr] <= '0;
    end else if (cmd.exec) begin
      if (st_we) mem_state[slot] <= wr_state;
      if (valid && r.action == ACT_FREE) mem_gen[slot] <= rd_gen + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (alloc && have) begin
        mem_data[slot] <= '0;
        mem_type[slot] <= r.res_type;
      end else if (valid && r.action == ACT_FREE) mem_data[slot] <= '0;
      else if (valid && r.action == ACT_SET_DATA) mem_data[slot] <= r.data_word;
      if (valid && r.action == ACT_FREE && stack_depth < CntW'(Capacity))
        mem_stack[stack_depth[IdxW-1:0]] <= slot;
    end
  end

  logic [CntW-1:0] act_next;
  always_comb begin
    act_next = active_total;
    if (st_we) begin
      if (was_act && !now_act && active_total != '0) act_next = active_total - 1'b1;
      else if (!was_act && now_act) act_next = active_total + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_depth <= '0;
      fresh_next <= CntW'(Capacity);
      active_total <= '0;
      done <= 1'b0;
    end else begin
      done <= cmd.exec;
      if (cmd.exec) begin
        active_total <= act_next;
        if (alloc && have) begin
          if (pop) stack_depth <= stack_depth - 1'b1;
          else fresh_next <= fresh_next - 1'b1;
        end else if (valid && r.action == ACT_FREE && stack_depth < CntW'(Capacity))
          stack_depth <= stack_depth + 1'b1;
      end
    end
  end

  rsp_t rsp_next;
  always_comb begin
    rsp_next = '0;
    rsp_next.active_count = 17'(act_next);
    if (alloc) begin
      if (have) begin
        rsp_next.ok = 1'b1;
        rsp_next.out_index = 16'(slot);
        rsp_next.out_generation = rd_gen;
        rsp_next.out_pool_id = r.pool_id;
      end
    end else if (r.action != ACT_NONE && valid) begin
      rsp_next.ok = 1'b1;
      if (r.action == ACT_GET_STATE) rsp_next.out_state = rd_state;
      if (r.action == ACT_GET_DATA) rsp_next.out_data = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) rsp <= rsp_next;
  end

  a_cnt: assert property (@(posedge clk) disable iff (rst)
    active_total <= CntW'(Capacity)) else $error("active count over capacity");
  a_stk: assert property (@(posedge clk) disable iff (rst)
    stack_depth <= CntW'(Capacity)) else $error("stack overflow");
  a_done: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> done) else $error("result strobe missing");
endmodule

FILE: design/generational_handle_pool.sv
// Top level of the generational handle pool.
// channel | signals                         | handshake
// cmd     | start, busy, request            | accepted when start && !busy
// result  | result_valid, result            | one cycle strobe, no stall
// cfg     | psel penable pwrite paddr pwdata | write when psel&penable&pwrite
// Each item passes capture, memory read and execute/write in turn; the result
// appears the cycle after execute. The slot memory's registered read sets this.
// After reset a clearing pass sweeps state and generation of all 1024 slots;
// busy stays high meanwhile. The receiver cannot stall results.
module generational_handle_pool (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ghp_pkg::req_t request,
  output logic          result_valid,
  output ghp_pkg::rsp_t result,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [1:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import ghp_pkg::*;
  cmd_t cmd;
  sts_t sts;
  logic pool_enable;

  assign pready = 1'b1;
  assign prdata = (paddr == RegPoolEnable) ? {31'd0, pool_enable} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) pool_enable <= 1'b1;
    else if (psel && penable && pwrite && paddr == RegPoolEnable) pool_enable <= pwdata[0];
  end

  ghp_ctrl u_ctrl (.clk, .rst, .start, .sts, .busy, .cmd);
  ghp_dp u_dp (.clk, .rst, .cmd, .req(request), .pool_enable, .sts,
    .done(result_valid), .rsp(result));
endmodule
